>>> rtl/pcm_decode_linear_resampler_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the PCM decode resampler
// Wraps concurrent assertions so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef PCM_DECODE_LINEAR_RESAMPLER_CORE_ASSERT_SVH
`define PCM_DECODE_LINEAR_RESAMPLER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define PDLR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pdlr assertion failed");

`define PDLR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pdlr assertion failed");

`else

`define PDLR_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define PDLR_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/pdlr_pkg.sv
// ----------------------------------------------------------------------------
// PCM decode resampler package
// Shared types and constants for the front end, queue and interpolator.
// ----------------------------------------------------------------------------
package pdlr_pkg;

	localparam int SAMPLE_W    = 32;
	localparam int STEP_W      = 29;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MONO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd2;

	localparam logic [STEP_W-1:0] STEP_RESET = 29'd16777216;

	typedef enum logic [1:0] {
		FMT_INT16,
		FMT_INT24,
		FMT_INT32,
		FMT_FLOAT32
	} fmt_t;

	typedef struct packed {
		fmt_t              fmt;
		logic              mono;
		logic [STEP_W-1:0] step;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic running;
		logic have_prior;
		logic acc_ok;
	} bk_stat_t;

endpackage

>>> rtl/pcm_decode_linear_resampler_core.sv
// ----------------------------------------------------------------------------
// PCM decode and linear-interpolation resampler with stereo output
// Decodes source frames to Q1.31 and interpolates them at the output rate.
// ----------------------------------------------------------------------------
// The results caused by a frame pass through the queue, the fetch into the
// interpolator, stage s1 and the output register. The interpolator emits one
// result per cycle while the output is not stalled and fetches each frame from
// the queue in its idle state, between runs; a frame yields at most MAX_RUN results.
// Reset restores the register defaults, empties the queue, clears the phase
// and discards the stored frame at once; no clearing pass is needed.
`include "pcm_decode_linear_resampler_core_assert.svh"

module pcm_decode_linear_resampler_core import pdlr_pkg::*; #(
	parameter int PHASE_FRAC_BITS = 24,
	parameter int MAX_RUN         = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [SAMPLE_W-1:0]        left_raw,
	input  logic [SAMPLE_W-1:0]        right_raw,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] left_out,
	output logic signed [SAMPLE_W-1:0] right_out,
	output logic                       last_of_run
);

	cfg_t     cfg_q;
	q_stat_t  q_stat;
	bk_stat_t bk_stat;
	logic     q_push;
	logic     q_pop;
	frame_t   q_wdata;
	frame_t   q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fmt  <= FMT_INT16;
			cfg_q.mono <= 1'b0;
			cfg_q.step <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FORMAT: cfg_q.fmt  <= fmt_t'(cfg_data[1:0]);
				CFG_MONO:   cfg_q.mono <= cfg_data[0];
				CFG_STEP:   cfg_q.step <= cfg_data[STEP_W-1:0];
				default:    cfg_q      <= cfg_q;
			endcase
		end
	end

	pdlr_front u_front (
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.left_raw  (left_raw),
		.right_raw (right_raw),
		.q_stat    (q_stat),
		.push      (q_push),
		.push_data (q_wdata)
	);

	pdlr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	pdlr_back #(
		.PHASE_FRAC_BITS (PHASE_FRAC_BITS),
		.MAX_RUN         (MAX_RUN)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_stat      (q_stat),
		.head        (q_head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_out    (left_out),
		.right_out   (right_out),
		.last_of_run (last_of_run),
		.stat        (bk_stat)
	);

	`PDLR_ASSERT_IMP(a_pop_not_empty, clk, arst_n, q_pop, !q_stat.empty)
	`PDLR_ASSERT_IMP(a_run_phase_below_one, clk, arst_n, bk_stat.running, bk_stat.acc_ok)
	`PDLR_ASSERT_NXT(a_no_output_before_prior, clk, arst_n, !bk_stat.have_prior, !out_valid)

endmodule

>>> rtl/pdlr_front.sv
// ----------------------------------------------------------------------------
// PCM decode resampler front end
// Accepts source frames, decodes both words to Q1.31 (only the left one in mono) and queues them.
// ----------------------------------------------------------------------------
module pdlr_front import pdlr_pkg::*; (
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SAMPLE_W-1:0] left_raw,
	input  logic [SAMPLE_W-1:0] right_raw,
	input  q_stat_t             q_stat,
	output logic                push,
	output frame_t              push_data
);

	function automatic logic [SAMPLE_W-1:0] float_to_q31(input logic [SAMPLE_W-1:0] bits);
		logic [7:0]          e;
		logic [SAMPLE_W-1:0] sig;
		logic [SAMPLE_W-1:0] mag;
		logic                sat;
		logic [SAMPLE_W-1:0] res;
		e   = bits[30:23];
		sig = {8'h00, 1'b1, bits[22:0]};
		sat = 1'b0;
		mag = '0;
		if (e == 8'hFF) begin
			sat = (bits[22:0] == 23'd0);
		end else if (e == 8'd0) begin
			mag = '0;
		end else if (e >= 8'd127) begin
			sat = 1'b1;
		end else if (e >= 8'd119) begin
			mag = sig << (e - 8'd119);
		end else if (e >= 8'd88) begin
			mag = sig >> (8'd119 - e);
		end else begin
			mag = '0;
		end
		if (sat) begin
			res = bits[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else if (bits[31]) begin
			res = ~mag + 32'd1;
		end else begin
			res = mag;
		end
		return res;
	endfunction

	function automatic logic [SAMPLE_W-1:0] decode_word(input logic [SAMPLE_W-1:0] raw,
			input fmt_t fmt);
		logic [SAMPLE_W-1:0] res;
		case (fmt)
			FMT_INT16:   res = {raw[15:0], 16'h0000};
			FMT_INT24:   res = {raw[23:0], 8'h00};
			FMT_INT32:   res = raw;
			FMT_FLOAT32: res = float_to_q31(raw);
			default:     res = '0;
		endcase
		return res;
	endfunction

	logic [SAMPLE_W-1:0] dec_left;

	assign dec_left       = decode_word(left_raw, cfg.fmt);
	assign in_stall       = q_stat.full;
	assign push           = in_valid && !q_stat.full;
	assign push_data.left = dec_left;
	assign push_data.right = cfg.mono ? dec_left : decode_word(right_raw, cfg.fmt);

endmodule

>>> rtl/pdlr_fifo.sv
// ----------------------------------------------------------------------------
// PCM decode resampler frame queue
// Short queue of decoded frames between the front end and the interpolator.
// ----------------------------------------------------------------------------
module pdlr_fifo import pdlr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  frame_t  push_data,
	input  logic    pop,
	output frame_t  head,
	output q_stat_t stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	frame_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/pdlr_back.sv
// ----------------------------------------------------------------------------
// PCM decode resampler interpolator
// Steps the phase over each queued frame and emits interpolated results.
// ----------------------------------------------------------------------------
module pdlr_back import pdlr_pkg::*; #(
	parameter int PHASE_FRAC_BITS = 24,
	parameter int MAX_RUN         = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  q_stat_t                    q_stat,
	input  frame_t                     head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] left_out,
	output logic signed [SAMPLE_W-1:0] right_out,
	output logic                       last_of_run,
	output bk_stat_t                   stat
);

	localparam int ACC_W  = ((PHASE_FRAC_BITS > STEP_W) ? PHASE_FRAC_BITS : STEP_W) + 1;
	localparam int FB     = (PHASE_FRAC_BITS > 30) ? 30 : PHASE_FRAC_BITS;
	localparam int DROP   = PHASE_FRAC_BITS - FB;
	localparam int RUN_W  = $clog2(MAX_RUN);
	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PROD_W = DIFF_W + FB + 1;
	localparam logic [ACC_W-1:0] ONE = {{(ACC_W - 1){1'b0}}, 1'b1} << PHASE_FRAC_BITS;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t                     state_q;
	logic [ACC_W-1:0]           acc_q;
	logic [RUN_W-1:0]           n_q;
	logic                       have_prior_q;
	logic [SAMPLE_W-1:0]        prior_l_q;
	logic [SAMPLE_W-1:0]        prior_r_q;
	logic [SAMPLE_W-1:0]        cur_l_q;
	logic [SAMPLE_W-1:0]        cur_r_q;

	logic                       valid_s1;
	logic signed [PROD_W-1:0]   prod_l_s1;
	logic signed [PROD_W-1:0]   prod_r_s1;
	logic [SAMPLE_W-1:0]        base_l_s1;
	logic [SAMPLE_W-1:0]        base_r_s1;
	logic                       last_s1;

	logic                       out_valid_q;
	logic [SAMPLE_W-1:0]        left_out_q;
	logic [SAMPLE_W-1:0]        right_out_q;
	logic                       last_q;

	logic [ACC_W-1:0]           step_ext;
	logic                       bypass;
	logic [ACC_W-1:0]           acc_next;
	logic [FB-1:0]              frac;
	logic signed [FB:0]         frac_s;
	logic signed [DIFF_W-1:0]   diff_l;
	logic signed [DIFF_W-1:0]   diff_r;
	logic signed [PROD_W-1:0]   prod_l;
	logic signed [PROD_W-1:0]   prod_r;
	logic signed [PROD_W-1:0]   shift_l;
	logic signed [PROD_W-1:0]   shift_r;
	logic                       adv_s1;
	logic                       issue;
	logic                       run_last;
	logic                       gap;

	assign step_ext = ACC_W'(cfg.step);
	assign bypass   = (step_ext == ONE);
	assign acc_next = acc_q + step_ext;
	assign gap      = !bypass && (acc_q >= ONE);
	assign frac     = bypass ? '0 : acc_q[PHASE_FRAC_BITS-1:DROP];
	assign frac_s   = $signed({1'b0, frac});
	assign diff_l   = $signed({cur_l_q[SAMPLE_W-1], cur_l_q})
		- $signed({prior_l_q[SAMPLE_W-1], prior_l_q});
	assign diff_r   = $signed({cur_r_q[SAMPLE_W-1], cur_r_q})
		- $signed({prior_r_q[SAMPLE_W-1], prior_r_q});
	assign prod_l   = diff_l * frac_s;
	assign prod_r   = diff_r * frac_s;
	assign shift_l  = prod_l_s1 >>> FB;
	assign shift_r  = prod_r_s1 >>> FB;

	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign issue    = (state_q == ST_RUN) && (!valid_s1 || adv_s1);
	assign run_last = bypass || (acc_next >= ONE) || (n_q == RUN_W'(MAX_RUN - 1));
	assign pop      = (state_q == ST_IDLE) && !q_stat.empty;

	assign out_valid   = out_valid_q;
	assign left_out    = $signed(left_out_q);
	assign right_out   = $signed(right_out_q);
	assign last_of_run = last_q;

	assign stat.running    = (state_q == ST_RUN);
	assign stat.have_prior = have_prior_q;
	assign stat.acc_ok     = bypass || (acc_q < ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			acc_q        <= '0;
			n_q          <= '0;
			have_prior_q <= 1'b0;
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						if (!have_prior_q) begin
							have_prior_q <= 1'b1;
						end else if (gap) begin
							acc_q <= acc_q - ONE;
						end else begin
							n_q     <= '0;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (issue) begin
						n_q <= n_q + 1'b1;
						if (run_last) begin
							state_q <= ST_IDLE;
							if (bypass || (acc_next < ONE)) begin
								acc_q <= '0;
							end else begin
								acc_q <= acc_next - ONE;
							end
						end else begin
							acc_q <= acc_next;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end

			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (!have_prior_q || gap) begin
				prior_l_q <= head.left;
				prior_r_q <= head.right;
			end else begin
				cur_l_q <= head.left;
				cur_r_q <= head.right;
			end
		end
		if (issue) begin
			prod_l_s1 <= prod_l;
			prod_r_s1 <= prod_r;
			base_l_s1 <= prior_l_q;
			base_r_s1 <= prior_r_q;
			last_s1   <= run_last;
			if (run_last) begin
				prior_l_q <= cur_l_q;
				prior_r_q <= cur_r_q;
			end
		end
		if (adv_s1) begin
			left_out_q  <= base_l_s1 + shift_l[SAMPLE_W-1:0];
			right_out_q <= base_r_s1 + shift_r[SAMPLE_W-1:0];
			last_q      <= last_s1;
		end
	end

endmodule

>>> bench/tb_pcm_decode_linear_resampler_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the PCM decode and linear-interpolation resampler
// Source frames are driven in every sample format, mono and stereo, at phase
// steps from zero through bypass to a downsampling ratio of sixteen. A
// scoreboard decodes each accepted frame, interpolates the expected results
// and compares every accepted result, in order, field by field.
// ----------------------------------------------------------------------------
module tb_pcm_decode_linear_resampler_core;
	import pdlr_pkg::*;

	localparam int FRAC_BITS      = 24;
	localparam int RUN_CAP        = 16;
	localparam logic [63:0] UNIT  = 64'd1 << FRAC_BITS;
	localparam int STEP_MIN       = 1048576;
	localparam int STEP_MAX       = 268435456;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SEGMENTS       = 9;
	localparam int SEGMENT_ITEMS  = 11;
	localparam int HOLD_CYCLES    = 300;

	typedef struct {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       last;
	} stereo_out_t;

	class resample_scoreboard;
		fmt_t                       fmt;
		logic                       mono;
		logic [63:0]                step;
		logic signed [SAMPLE_W-1:0] prior_l;
		logic signed [SAMPLE_W-1:0] prior_r;
		logic                       have_prior;
		logic [63:0]                phase;
		stereo_out_t                expected_out[$];
		int                         errors;
		int                         frames;
		int                         results;

		function new();
			fmt = FMT_INT16;
			mono = 1'b0;
			step = 64'(STEP_RESET);
			prior_l = '0;
			prior_r = '0;
			have_prior = 1'b0;
			phase = '0;
			errors = 0;
			frames = 0;
			results = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_FORMAT: fmt = fmt_t'(val[1:0]);
				CFG_MONO:   mono = val[0];
				CFG_STEP:   step = 64'(val[STEP_W-1:0]);
				default: ;
			endcase
		endfunction

		function logic signed [SAMPLE_W-1:0] float_to_fixed(logic [31:0] w);
			logic [7:0]  ex;
			logic [63:0] sig;
			logic [63:0] mag;
			int          sh;
			ex = w[30:23];
			sig = {40'd0, 1'b1, w[22:0]};
			if (ex == 8'hFF) begin
				if (w[22:0] != 23'd0)
					return '0;
				mag = 64'd1 << 40;
			end else if (ex == 8'd0) begin
				mag = '0;
			end else begin
				sh = int'(ex) - 119;
				if (sh >= 8)
					mag = 64'd1 << 40;
				else if (sh >= 0)
					mag = sig << sh;
				else if (-sh >= 32)
					mag = '0;
				else
					mag = sig >> (-sh);
			end
			if (w[31]) begin
				if (mag > 64'h8000_0000)
					mag = 64'h8000_0000;
				return ~mag[31:0] + 32'd1;
			end
			if (mag > 64'h7FFF_FFFF)
				mag = 64'h7FFF_FFFF;
			return mag[31:0];
		endfunction

		function logic signed [SAMPLE_W-1:0] decode_word(logic [31:0] raw);
			case (fmt)
				FMT_INT16: return {raw[15:0], 16'd0};
				FMT_INT24: return {raw[23:0], 8'd0};
				FMT_INT32: return raw;
				default:   return float_to_fixed(raw);
			endcase
		endfunction

		// Rounds toward minus infinity through the arithmetic shift.
		function logic signed [SAMPLE_W-1:0] interp(logic signed [SAMPLE_W-1:0] a,
				logic signed [SAMPLE_W-1:0] b, logic [63:0] frac);
			longint prod;
			prod = (longint'(b) - longint'(a)) * longint'(frac);
			return 32'(longint'(a) + (prod >>> FRAC_BITS));
		endfunction

		function void take_frame(logic [31:0] lraw, logic [31:0] rraw);
			logic signed [SAMPLE_W-1:0] cur_l;
			logic signed [SAMPLE_W-1:0] cur_r;
			stereo_out_t                o;
			int                         n;
			cur_l = decode_word(lraw);
			cur_r = mono ? cur_l : decode_word(rraw);
			n = 0;
			frames++;
			if (have_prior) begin
				if (step == UNIT) begin
					o.left = prior_l;
					o.right = prior_r;
					o.last = 1'b0;
					expected_out.insert(expected_out.size(), o);
					n = 1;
					phase = '0;
				end else begin
					while (phase < UNIT && n < RUN_CAP) begin
						o.left = interp(prior_l, cur_l, phase);
						o.right = interp(prior_r, cur_r, phase);
						o.last = 1'b0;
						expected_out.insert(expected_out.size(), o);
						n++;
						phase += step;
					end
					phase = (phase >= UNIT) ? phase - UNIT : 64'd0;
				end
				if (n > 0)
					expected_out[expected_out.size() - 1].last = 1'b1;
			end
			prior_l = cur_l;
			prior_r = cur_r;
			have_prior = 1'b1;
		endfunction

		function void check_output(logic signed [SAMPLE_W-1:0] l,
				logic signed [SAMPLE_W-1:0] r, logic last);
			stereo_out_t e;
			if (expected_out.size() == 0) begin
				$display("%0t unexpected result: expected none, got left %h right %h last %b",
					$time, l, r, last);
				errors++;
				return;
			end
			e = expected_out.pop_front();
			results++;
			if (l !== e.left) begin
				$display("%0t left_out: expected %h, got %h", $time, e.left, l);
				errors++;
			end
			if (r !== e.right) begin
				$display("%0t right_out: expected %h, got %h", $time, e.right, r);
				errors++;
			end
			if (last !== e.last) begin
				$display("%0t last_of_run: expected %b, got %b", $time, e.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_out.size();
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic [SAMPLE_W-1:0]        left_raw;
	logic [SAMPLE_W-1:0]        right_raw;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;
	logic                       last_of_run;

	resample_scoreboard sb;
	int                 snd_idle_pct;
	int                 rcv_stall_pct;
	int                 hold_req;
	int                 hold_left;
	int                 quiet_cycles;
	int                 reg_writes;

	pcm_decode_linear_resampler_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.left_raw    (left_raw),
		.right_raw   (right_raw),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_out    (left_out),
		.right_out   (right_out),
		.last_of_run (last_of_run)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_output(left_out, right_out, last_of_run);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("pcm_decode_linear_resampler_core: mismatch");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_register(idx, val);
		reg_writes++;
	endtask

	task automatic send_frame(input logic [31:0] l, input logic [31:0] r);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_raw <= l;
		right_raw <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.take_frame(l, r);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input fmt_t f, input logic m, input logic [CFG_DATA_W-1:0] s);
		settle();
		write_reg(CFG_FORMAT, CFG_DATA_W'(f));
		write_reg(CFG_MONO, CFG_DATA_W'(m));
		write_reg(CFG_STEP, s);
	endtask

	function automatic logic [31:0] random_word(input fmt_t f);
		logic [31:0] w;
		w = $urandom();
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 7))
				0: w = 32'h7FFF_FFFF;
				1: w = 32'h8000_0000;
				2: w = 32'h0000_7FFF;
				3: w = 32'h0000_8000;
				4: w = 32'h007F_FFFF;
				5: w = 32'h0080_0000;
				6: w = 32'h0000_0000;
				default: w = 32'hFFFF_FFFF;
			endcase
		end else if (f == FMT_FLOAT32 && $urandom_range(0, 1) == 1) begin
			w[30:23] = 8'($urandom_range(100, 128));
		end
		return w;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_step();
		case ($urandom_range(0, 3))
			0: return CFG_DATA_W'(STEP_RESET);
			1: return $urandom_range(STEP_MIN, 32'(UNIT));
			2: return $urandom_range(32'(UNIT), 3 * 32'(UNIT));
			default: return $urandom_range(STEP_MIN, STEP_MAX);
		endcase
	endfunction

	// A nonzero hold stalls the receiver while the frames of the segment are offered.
	task automatic random_segment(input int count, input int hold);
		fmt_t                  f;
		logic [CFG_DATA_W-1:0] s;
		f = fmt_t'($urandom_range(0, 3));
		s = (hold > 0) ? CFG_DATA_W'(UNIT / 2) : random_step();
		configure(f, 1'($urandom_range(0, 1)), s);
		hold_req = hold;
		repeat (count) send_frame(random_word(f), random_word(f));
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		left_raw = '0;
		right_raw = '0;
		out_stall = 1'b0;
		hold_req = 0;
		hold_left = 0;
		quiet_cycles = 0;
		reg_writes = 0;
		snd_idle_pct = 27;
		rcv_stall_pct = 77;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_frame(32'h0000_7FFF, 32'hFFFF_8000);
		send_frame(32'hABCD_8000, 32'h1234_7FFF);
		send_frame(32'h0000_0000, 32'hFFFF_FFFF);

		configure(FMT_INT24, 1'b0, 32'd0);
		send_frame(32'h007F_FFFF, 32'hFF80_0000);
		send_frame(32'h0080_0000, 32'h007F_FFFF);

		configure(FMT_INT32, 1'b1, STEP_MIN);
		send_frame(32'h7FFF_FFFF, 32'h1234_5678);
		send_frame(32'h8000_0000, 32'hFFFF_FFFF);
		send_frame(32'h0000_0001, 32'h0000_0000);

		configure(FMT_FLOAT32, 1'b0, 32'd25165824);
		send_frame(32'h7FC0_0000, 32'h7F80_0000);
		send_frame(32'hFF80_0000, 32'h3F80_0000);
		send_frame(32'hBF80_0000, 32'h3F00_0000);
		send_frame(32'h0000_0001, 32'h2F80_0000);
		send_frame(32'h3000_0000, 32'h8000_0000);
		send_frame(32'h3F7F_FFFF, 32'hCF00_0001);

		configure(FMT_INT16, 1'b0, STEP_MAX);
		send_frame(32'h0000_8000, 32'h0000_7FFF);
		send_frame(32'h0000_7FFF, 32'h0000_8000);
		send_frame(32'h0000_1234, 32'h0000_FEDC);
		send_frame(32'h0000_0001, 32'h0000_FFFF);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg == SEGMENTS / 3) begin
				snd_idle_pct = 77;
				rcv_stall_pct = 27;
			end else if (seg == 2 * SEGMENTS / 3) begin
				snd_idle_pct = 0;
				rcv_stall_pct = 0;
			end
			random_segment(SEGMENT_ITEMS, (seg == 2 * SEGMENTS / 3) ? HOLD_CYCLES : 0);
		end
		settle();

		$display("Ran %0d frames in all formats, mono and stereo, with phase steps from zero",
			sb.frames);
		$display("to sixteen; %0d results checked after %0d register writes.", sb.results,
			reg_writes);
		if (sb.errors == 0)
			$display("pcm_decode_linear_resampler_core: match");
		else
			$display("pcm_decode_linear_resampler_core: mismatch");
		$finish;
	end
endmodule
